@@ rtl/fmr_pkg.sv @@
// fmr_pkg: shared types and constants of the framed message receiver.
// Used by the channel interfaces and the receiver top level; no dependencies.
package fmr_pkg;

    localparam int RX_W    = 8;
    localparam int ID_W    = 8;
    localparam int EVT_W   = 2;
    localparam int BIDX_W  = 5;
    localparam int LEN_W   = 6;
    localparam int APB_AW  = 5;
    localparam int APB_DW  = 32;

    typedef logic [EVT_W-1:0] t_event;

    localparam t_event EV_BYTE  = 2'd0;
    localparam t_event EV_DONE  = 2'd1;
    localparam t_event EV_ERROR = 2'd2;

    typedef logic [2:0] t_reg_idx;

    localparam t_reg_idx REG_START    = 3'd0;
    localparam t_reg_idx REG_STOP     = 3'd1;
    localparam t_reg_idx REG_LEN_EN   = 3'd2;
    localparam t_reg_idx REG_LEN_ATT  = 3'd3;
    localparam t_reg_idx REG_LEN_SPD  = 3'd4;
    localparam t_reg_idx REG_LEN_DUTY = 3'd5;

endpackage

@@ rtl/fmr_rx_if.sv @@
// fmr_rx_if: valid/ready channel carrying one received byte per word.
// Depends on fmr_pkg for field widths.
interface fmr_rx_if;
    logic                     valid;
    logic                     ready;
    logic [fmr_pkg::RX_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ rtl/fmr_ev_if.sv @@
// fmr_ev_if: valid/ready channel carrying one parser event per word.
// Depends on fmr_pkg for field widths and the event type.
interface fmr_ev_if;
    logic                       valid;
    logic                       ready;
    fmr_pkg::t_event            event_res;
    logic [fmr_pkg::ID_W-1:0]   message_id;
    logic [fmr_pkg::BIDX_W-1:0] byte_index;
    logic [fmr_pkg::RX_W-1:0]   payload_byte;
    logic                       last;

    modport source (output valid, output event_res, output message_id, output byte_index,
                    output payload_byte, output last, input ready);
    modport sink   (input valid, input event_res, input message_id, input byte_index,
                    input payload_byte, input last, output ready);
endinterface

@@ rtl/framed_message_receiver.sv @@
// A word that causes a single event shows it on the output in the cycle after acceptance.
// A good stop byte with n payload bytes: each word takes a store read (S_EMIT_RD), then an
// output load (S_EMIT_LD) that waits on a held output; the input is held off until the last load.
// Throughput: one byte per cycle while no payload is being walked out of the store and the output is not held.
// Reset (synchronous, active low) clears the frame state, registers and output valid;
// the payload store is not cleared and needs no clearing pass.
module framed_message_receiver #(
    parameter int MAX_PAYLOAD = 32,
    parameter int ID_ENABLE   = 1,
    parameter int ID_ATTITUDE = 2,
    parameter int ID_SPEED    = 3,
    parameter int ID_DUTY     = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    fmr_rx_if.sink                      i_rx,
    fmr_ev_if.source                    o_ev,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fmr_pkg::APB_AW-1:0]  paddr,
    input  logic [fmr_pkg::APB_DW-1:0]  pwdata,
    output logic [fmr_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    localparam int CAPACITY = (MAX_PAYLOAD < 32) ? MAX_PAYLOAD : 32;
    localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [fmr_pkg::LEN_W-1:0] CAP_LEN = fmr_pkg::LEN_W'(CAPACITY);

    typedef enum logic [1:0] {
        S_RUN,
        S_EMIT_RD,
        S_EMIT_LD
    } t_state;

    // configuration
    logic [fmr_pkg::RX_W-1:0]  r_start_code, r_stop_code;
    logic [fmr_pkg::LEN_W-1:0] r_len_en, r_len_att, r_len_spd, r_len_duty;
    logic                      cfg_wr;

    // frame state
    t_state                    r_state, n_state;
    logic                      r_in_frame, n_in_frame;
    logic [fmr_pkg::LEN_W-1:0] r_idx, n_idx;
    logic [fmr_pkg::LEN_W-1:0] r_exp_len, n_exp_len;
    logic [fmr_pkg::ID_W-1:0]  r_frame_id, n_frame_id;
    logic [fmr_pkg::LEN_W-1:0] r_emit_idx, n_emit_idx;

    // output register
    logic                       r_out_valid, n_out_valid;
    fmr_pkg::t_event            r_out_evt, n_out_evt;
    logic [fmr_pkg::ID_W-1:0]   r_out_id, n_out_id;
    logic [fmr_pkg::BIDX_W-1:0] r_out_bidx, n_out_bidx;
    logic [fmr_pkg::RX_W-1:0]   r_out_byte, n_out_byte;
    logic                       r_out_last, n_out_last;

    logic                      out_free, rx_fire;
    logic [fmr_pkg::RX_W-1:0]  rx_b;
    logic [fmr_pkg::LEN_W-1:0] raw_len, sat_len, idx_m1;
    logic                      id_known;
    logic                      ram_we, ram_re;
    logic [fmr_pkg::RX_W-1:0]  ram_rdata;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_code <= '0;
            r_stop_code  <= '0;
            r_len_en     <= '0;
            r_len_att    <= '0;
            r_len_spd    <= '0;
            r_len_duty   <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                fmr_pkg::REG_START:    r_start_code <= pwdata[7:0];
                fmr_pkg::REG_STOP:     r_stop_code  <= pwdata[7:0];
                fmr_pkg::REG_LEN_EN:   r_len_en     <= pwdata[5:0];
                fmr_pkg::REG_LEN_ATT:  r_len_att    <= pwdata[5:0];
                fmr_pkg::REG_LEN_SPD:  r_len_spd    <= pwdata[5:0];
                fmr_pkg::REG_LEN_DUTY: r_len_duty   <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            fmr_pkg::REG_START:    prdata = fmr_pkg::APB_DW'(r_start_code);
            fmr_pkg::REG_STOP:     prdata = fmr_pkg::APB_DW'(r_stop_code);
            fmr_pkg::REG_LEN_EN:   prdata = fmr_pkg::APB_DW'(r_len_en);
            fmr_pkg::REG_LEN_ATT:  prdata = fmr_pkg::APB_DW'(r_len_att);
            fmr_pkg::REG_LEN_SPD:  prdata = fmr_pkg::APB_DW'(r_len_spd);
            fmr_pkg::REG_LEN_DUTY: prdata = fmr_pkg::APB_DW'(r_len_duty);
            default:               prdata = '0;
        endcase
    end

    // ---------------- identifier lookup ----------------
    assign rx_b = i_rx.rx_byte;

    // first match wins when identifiers collide
    always_comb begin
        priority if (rx_b == 8'(ID_ENABLE))   raw_len = r_len_en;
        else if     (rx_b == 8'(ID_ATTITUDE)) raw_len = r_len_att;
        else if     (rx_b == 8'(ID_SPEED))    raw_len = r_len_spd;
        else if     (rx_b == 8'(ID_DUTY))     raw_len = r_len_duty;
        else                                  raw_len = '0;
    end

    assign sat_len  = (raw_len > CAP_LEN) ? CAP_LEN : raw_len;
    assign id_known = (r_frame_id == 8'(ID_ENABLE))   || (r_frame_id == 8'(ID_ATTITUDE)) ||
                      (r_frame_id == 8'(ID_SPEED))    || (r_frame_id == 8'(ID_DUTY));

    // ---------------- payload store ----------------
    assign idx_m1 = r_idx - 6'd1;
    assign ram_we = rx_fire && r_in_frame && (r_idx != '0) && (r_idx <= r_exp_len);
    assign ram_re = (r_state == S_EMIT_RD);

    fmr_ram #(
        .WIDTH (fmr_pkg::RX_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (idx_m1[AW-1:0]),
        .i_wdata (rx_b),
        .i_re    (ram_re),
        .i_raddr (r_emit_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // ---------------- parser ----------------
    assign out_free   = !r_out_valid || o_ev.ready;
    assign i_rx.ready = (r_state == S_RUN) && out_free;
    assign rx_fire    = i_rx.valid && i_rx.ready;

    always_comb begin
        n_state     = r_state;
        n_in_frame  = r_in_frame;
        n_idx       = r_idx;
        n_exp_len   = r_exp_len;
        n_frame_id  = r_frame_id;
        n_emit_idx  = r_emit_idx;
        n_out_valid = r_out_valid && !o_ev.ready;
        n_out_evt   = r_out_evt;
        n_out_id    = r_out_id;
        n_out_bidx  = r_out_bidx;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;

        unique case (r_state)
            S_RUN: begin
                if (rx_fire) begin
                    priority if (!r_in_frame) begin
                        if (rx_b == r_start_code) begin
                            n_in_frame = 1'b1;
                            n_idx      = '0;
                        end else begin
                            n_out_valid = 1'b1;
                            n_out_evt   = fmr_pkg::EV_ERROR;
                            n_out_id    = '0;
                            n_out_bidx  = '0;
                            n_out_byte  = '0;
                            n_out_last  = 1'b1;
                        end
                    end else if (r_idx == '0) begin
                        n_frame_id = rx_b;
                        n_exp_len  = sat_len;
                        n_idx      = 6'd1;
                    end else if (r_idx <= r_exp_len) begin
                        n_idx = r_idx + 6'd1;
                    end else begin
                        // closing byte
                        n_in_frame  = 1'b0;
                        n_idx       = '0;
                        n_out_bidx  = '0;
                        n_out_byte  = '0;
                        n_out_last  = 1'b1;
                        priority if (rx_b != r_stop_code) begin
                            n_out_valid = 1'b1;
                            n_out_evt   = fmr_pkg::EV_ERROR;
                            n_out_id    = '0;
                        end else if (!id_known) begin
                            n_out_valid = 1'b1;
                            n_out_evt   = fmr_pkg::EV_ERROR;
                            n_out_id    = r_frame_id;
                        end else if (r_exp_len == '0) begin
                            n_out_valid = 1'b1;
                            n_out_evt   = fmr_pkg::EV_DONE;
                            n_out_id    = r_frame_id;
                        end else begin
                            n_emit_idx = '0;
                            n_state    = S_EMIT_RD;
                        end
                    end
                end
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                // store read data holds until the next read is issued
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_evt   = fmr_pkg::EV_BYTE;
                    n_out_id    = r_frame_id;
                    n_out_bidx  = r_emit_idx[fmr_pkg::BIDX_W-1:0];
                    n_out_byte  = ram_rdata;
                    n_out_last  = (r_emit_idx + 6'd1 == r_exp_len);
                    n_emit_idx  = r_emit_idx + 6'd1;
                    n_state     = (r_emit_idx + 6'd1 == r_exp_len) ? S_RUN : S_EMIT_RD;
                end
            end
            default: n_state = S_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_in_frame  <= 1'b0;
            r_idx       <= '0;
            r_exp_len   <= '0;
            r_frame_id  <= '0;
            r_emit_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_frame  <= n_in_frame;
            r_idx       <= n_idx;
            r_exp_len   <= n_exp_len;
            r_frame_id  <= n_frame_id;
            r_emit_idx  <= n_emit_idx;
            r_out_valid <= n_out_valid;
        end
        r_out_evt  <= n_out_evt;
        r_out_id   <= n_out_id;
        r_out_bidx <= n_out_bidx;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_ev.valid        = r_out_valid;
    assign o_ev.event_res    = r_out_evt;
    assign o_ev.message_id   = r_out_id;
    assign o_ev.byte_index   = r_out_bidx;
    assign o_ev.payload_byte = r_out_byte;
    assign o_ev.last         = r_out_last;

    // ---------------- checks ----------------
    a_no_rx_while_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_RUN) |-> !i_rx.ready)
        else $error("input taken while payload is walked out");

    a_emit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_RUN) |-> (r_emit_idx < r_exp_len) && !r_in_frame)
        else $error("emit index past frame length");

    a_store_write_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (idx_m1 < CAP_LEN) && (r_state == S_RUN))
        else $error("store write outside payload range");

    a_read_then_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT_RD) |=> (r_state == S_EMIT_LD))
        else $error("store read not followed by output load");

    a_byte_last_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT_LD) && out_free && (r_emit_idx + 6'd1 == r_exp_len)
        |=> (r_state == S_RUN) && r_out_valid && r_out_last)
        else $error("final payload word not flagged last");

endmodule

@@ rtl/fmr_ram.sv @@
// fmr_ram: generic single-port-write, single-port-read RAM with registered read.
// Standalone; no package dependency.
module fmr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
